// ===== src/dwmc_pkg.sv =====
// ---------------------------------------------------------------------------
// dwmc_pkg
// Shared constants and types of the dense window mask cleaner.
// ---------------------------------------------------------------------------
package dwmc_pkg;

	// Frame geometry.
	localparam int MAX_WIDTH   = 640;
	localparam int MAX_HEIGHT  = 480;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int COL_W       = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FRAME_W     = $clog2(STORE_DEPTH + 1);

	// Register field widths.
	localparam int MASK_WIDTH_W  = 10;
	localparam int MASK_HEIGHT_W = 9;
	localparam int SIDE_W        = 8;
	localparam int THR_W         = 10;
	localparam int CFG_DATA_W    = 10;
	localparam int CFG_INDEX_W   = 2;

	// Window arithmetic widths.
	localparam int STRIDE_W   = SIDE_W - 1;
	localparam int AREA_W     = 2 * SIDE_W;
	localparam int Q10_SHIFT  = 10;
	localparam int LIM_W      = AREA_W + THR_W;

	// Register reset values and limits.
	localparam int RST_MASK_WIDTH  = 640;
	localparam int RST_MASK_HEIGHT = 480;
	localparam int RST_WINDOW_SIZE = 50;
	localparam int RST_THRESHOLD   = 614;
	localparam int MIN_SIDE        = 3;
	localparam int THR_LOW         = 11;
	localparam int THR_HIGH        = 1013;
	localparam int THR_FALLBACK    = 205;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MASK_WIDTH  = 2'd0,
		REG_MASK_HEIGHT = 2'd1,
		REG_WINDOW_SIZE = 2'd2,
		REG_THRESHOLD   = 2'd3
	} reg_index_t;

	// Item action codes.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Frame store access requested by the window sequencer.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
	} pass_mem_t;

endpackage

// ===== src/dwmc_if.sv =====
// ---------------------------------------------------------------------------
// dwmc_if
// Valid/ready channels of the dense window mask cleaner.
// ---------------------------------------------------------------------------

// Input items: pixel loads and result reads.
interface dwmc_item_if;
	logic valid;
	logic ready;
	logic action;
	logic pixel_on;
	logic frame_end;

	modport source (output valid, action, pixel_on, frame_end, input ready);
	modport sink (input valid, action, pixel_on, frame_end, output ready);
endinterface

// Result items: one processed pixel per read.
interface dwmc_result_if;
	logic valid;
	logic ready;
	logic result_pixel;
	logic last_pixel;

	modport source (output valid, result_pixel, last_pixel, input ready);
	modport sink (input valid, result_pixel, last_pixel, output ready);
endinterface

// Configuration register writes.
interface dwmc_cfg_if import dwmc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dwmc_ram.sv =====
// ---------------------------------------------------------------------------
// dwmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dwmc_ram #(
	parameter int DATA_W = 1,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port returns the old contents on a same-cycle write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dwmc_pass.sv =====
// ---------------------------------------------------------------------------
// dwmc_pass
// Window sequencer: walks the windows, counts set pixels through the frame
// store read port and clears dense windows through the write port.
// ---------------------------------------------------------------------------
module dwmc_pass import dwmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [COL_W-1:0]  eff_w,
	input  logic [ROW_W-1:0]  eff_h,
	input  logic [SIDE_W-1:0] side,
	input  logic [THR_W-1:0]  thr,
	input  logic              rd_data,
	output logic              busy,
	output pass_mem_t         mem
);

	typedef enum logic [8:0] {
		P_IDLE   = 9'b000000001,
		P_START  = 9'b000000010,
		P_SIZE   = 9'b000000100,
		P_AREA   = 9'b000001000,
		P_COUNT  = 9'b000010000,
		P_DRAIN  = 9'b000100000,
		P_DECIDE = 9'b001000000,
		P_CLEAR  = 9'b010000000,
		P_NEXT   = 9'b100000000
	} pass_state_t;

	localparam int NX_W = COL_W + STRIDE_W;
	localparam int NY_W = ROW_W + STRIDE_W;

	pass_state_t         state_q;
	logic                cnt_s1;
	logic [COL_W-1:0]    x_q;
	logic [ROW_W-1:0]    y_q;
	logic [FRAME_W-1:0]  base_q;
	logic [FRAME_W-1:0]  rowbase_q;
	logic [FRAME_W-1:0]  stride_w_q;
	logic [FRAME_W-1:0]  addr_q;
	logic [FRAME_W-1:0]  line_q;
	logic [SIDE_W-1:0]   ww_q;
	logic [SIDE_W-1:0]   wh_q;
	logic [SIDE_W-1:0]   r_q;
	logic [SIDE_W-1:0]   c_q;
	logic [AREA_W-1:0]   area_q;
	logic [AREA_W-1:0]   cnt_q;
	logic [LIM_W-1:0]    lim_q;

	logic [STRIDE_W-1:0] stride;
	logic [COL_W-1:0]    rem_w;
	logic [ROW_W-1:0]    rem_h;
	logic [NX_W-1:0]     nx;
	logic [NY_W-1:0]     ny;
	logic                x_more;
	logic                y_more;
	logic                col_end;
	logic                row_end;
	logic                dense;

	// Window stepping and walk position.
	always_comb begin
		stride  = side[SIDE_W-1:1];
		rem_w   = eff_w - x_q;
		rem_h   = eff_h - y_q;
		nx      = NX_W'(x_q) + NX_W'(stride);
		ny      = NY_W'(y_q) + NY_W'(stride);
		x_more  = nx < NX_W'(eff_w);
		y_more  = ny < NY_W'(eff_h);
		col_end = c_q == (ww_q - SIDE_W'(1));
		row_end = r_q == (wh_q - SIDE_W'(1));
		dense   = {cnt_q, Q10_SHIFT'(0)} > lim_q;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cnt_s1  <= 1'b0;
		end else begin
			cnt_s1 <= state_q == P_COUNT;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_START;
					end
				end
				P_START:  state_q <= P_SIZE;
				P_SIZE:   state_q <= P_AREA;
				P_AREA:   state_q <= P_COUNT;
				P_COUNT: begin
					if (col_end && row_end) begin
						state_q <= P_DRAIN;
					end
				end
				P_DRAIN:  state_q <= P_DECIDE;
				P_DECIDE: state_q <= dense ? P_CLEAR : P_NEXT;
				P_CLEAR: begin
					if (col_end && row_end) begin
						state_q <= P_NEXT;
					end
				end
				P_NEXT:   state_q <= (x_more || y_more) ? P_SIZE : P_IDLE;
				default:  state_q <= P_IDLE;
			endcase
		end
	end

	// Window datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			P_START: begin
				stride_w_q <= FRAME_W'(stride * eff_w);
				x_q        <= '0;
				y_q        <= '0;
				base_q     <= '0;
				rowbase_q  <= '0;
			end
			P_SIZE: begin
				if (int'(rem_w) < int'(side)) begin
					ww_q <= SIDE_W'(rem_w);
				end else begin
					ww_q <= side;
				end
				if (int'(rem_h) < int'(side)) begin
					wh_q <= SIDE_W'(rem_h);
				end else begin
					wh_q <= side;
				end
				addr_q <= base_q;
				line_q <= base_q;
				r_q    <= '0;
				c_q    <= '0;
			end
			P_AREA: begin
				area_q <= ww_q * wh_q;
			end
			P_COUNT, P_CLEAR: begin
				if (col_end) begin
					c_q    <= '0;
					r_q    <= r_q + SIDE_W'(1);
					line_q <= line_q + FRAME_W'(eff_w);
					addr_q <= line_q + FRAME_W'(eff_w);
				end else begin
					c_q    <= c_q + SIDE_W'(1);
					addr_q <= addr_q + FRAME_W'(1);
				end
			end
			P_DECIDE: begin
				addr_q <= base_q;
				line_q <= base_q;
				r_q    <= '0;
				c_q    <= '0;
			end
			P_NEXT: begin
				if (x_more) begin
					x_q    <= nx[COL_W-1:0];
					base_q <= base_q + FRAME_W'(stride);
				end else if (y_more) begin
					x_q       <= '0;
					y_q       <= ny[ROW_W-1:0];
					rowbase_q <= rowbase_q + stride_w_q;
					base_q    <= rowbase_q + stride_w_q;
				end
			end
			default: ;
		endcase

		// Count starts from zero ahead of each window; read data lands in the cycle after the read.
		if (state_q == P_AREA) begin
			cnt_q <= '0;
		end else if (cnt_s1) begin
			cnt_q <= cnt_q + AREA_W'(rd_data);
		end

		// Q10 limit: threshold times area.
		lim_q <= LIM_W'(thr * area_q);
	end

	// Store access.
	always_comb begin
		busy        = state_q != P_IDLE;
		mem.rd_en   = state_q == P_COUNT;
		mem.rd_addr = addr_q[ADDR_W-1:0];
		mem.wr_en   = state_q == P_CLEAR;
		mem.wr_addr = addr_q[ADDR_W-1:0];
	end

endmodule

// ===== src/dense_window_mask_clear.sv =====
// ---------------------------------------------------------------------------
// dense_window_mask_clear
// Frame-store mask cleaner with a window density pass.
// ---------------------------------------------------------------------------
// Load beats write one mask pixel each into a one-bit frame store and are
// taken one per cycle while the item channel is not stalled. A load beat
// with frame_end starts the window pass; the item channel stays stalled
// until the pass is done. The pass first sets up, then for each window
// sizes it, forms its area, counts its set pixels, drains the last read,
// decides, clears the window when it is dense and steps to the next one;
// it reads and clears the store one pixel per cycle through its single
// read and single write port. Read beats return one processed pixel each;
// no new item is taken while a read is in the store read stage ahead of
// the output register. The store has no reset: read only pixels loaded
// since reset. There is no clearing pass. Configuration writes are taken
// in every cycle and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module dense_window_mask_clear import dwmc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dwmc_item_if.sink      item,
	dwmc_result_if.source  result,
	dwmc_cfg_if.sink       cfg
);

	logic [MASK_WIDTH_W-1:0]  mask_width_q;
	logic [MASK_HEIGHT_W-1:0] mask_height_q;
	logic [SIDE_W-1:0]        window_size_q;
	logic [THR_W-1:0]         threshold_q;
	logic [FRAME_W-1:0]       load_q;
	logic [FRAME_W-1:0]       read_q;
	logic                     rd_s1;
	logic                     last_s1;
	logic                     out_valid_q;
	logic                     result_q;
	logic                     last_q;

	logic [COL_W-1:0]   eff_w;
	logic [ROW_W-1:0]   eff_h;
	logic [SIDE_W-1:0]  side;
	logic [THR_W-1:0]   thr;
	logic [FRAME_W-1:0] frame_size;
	logic [FRAME_W-1:0] rd_addr;
	logic [FRAME_W-1:0] rd_next;
	logic               accept;
	logic               load_acc;
	logic               read_acc;
	logic               load_wr;
	logic               pass_busy;
	logic               store_rdata;
	pass_mem_t          pass_mem;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;

	// Effective configuration values.
	always_comb begin
		if (mask_width_q == '0) begin
			eff_w = COL_W'(1);
		end else if (int'(mask_width_q) > MAX_WIDTH) begin
			eff_w = COL_W'(MAX_WIDTH);
		end else begin
			eff_w = COL_W'(mask_width_q);
		end
		if (mask_height_q == '0) begin
			eff_h = ROW_W'(1);
		end else if (int'(mask_height_q) > MAX_HEIGHT) begin
			eff_h = ROW_W'(MAX_HEIGHT);
		end else begin
			eff_h = ROW_W'(mask_height_q);
		end
		if (int'(window_size_q) < MIN_SIDE) begin
			side = SIDE_W'(MIN_SIDE);
		end else begin
			side = window_size_q;
		end
		if (int'(threshold_q) < THR_LOW || int'(threshold_q) > THR_HIGH) begin
			thr = THR_W'(THR_FALLBACK);
		end else begin
			thr = threshold_q;
		end
		frame_size = FRAME_W'(eff_w * eff_h);
	end

	// Item handshake and read address stepping.
	always_comb begin
		item.ready = !pass_busy && !rd_s1 && (!out_valid_q || result.ready);
		accept     = item.valid && item.ready;
		load_acc   = accept && (item.action == ACT_LOAD);
		read_acc   = accept && (item.action == ACT_READ);
		load_wr    = load_acc && (load_q < frame_size);
		rd_addr    = (read_q >= frame_size) ? '0 : read_q;
		rd_next    = rd_addr + FRAME_W'(1);
		if (rd_next >= frame_size) begin
			rd_next = '0;
		end
	end

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q  <= MASK_WIDTH_W'(RST_MASK_WIDTH);
			mask_height_q <= MASK_HEIGHT_W'(RST_MASK_HEIGHT);
			window_size_q <= SIDE_W'(RST_WINDOW_SIZE);
			threshold_q   <= THR_W'(RST_THRESHOLD);
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_MASK_WIDTH:  mask_width_q  <= cfg.data[MASK_WIDTH_W-1:0];
				REG_MASK_HEIGHT: mask_height_q <= cfg.data[MASK_HEIGHT_W-1:0];
				REG_WINDOW_SIZE: window_size_q <= cfg.data[SIDE_W-1:0];
				REG_THRESHOLD:   threshold_q   <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Load and read positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			read_q <= '0;
		end else if (load_acc && item.frame_end) begin
			load_q <= '0;
			read_q <= '0;
		end else if (load_acc) begin
			load_q <= load_wr ? load_q + FRAME_W'(1) : frame_size;
		end else if (read_acc) begin
			read_q <= rd_next;
		end
	end

	// Read pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= read_acc;
			if (rd_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc) begin
			last_s1 <= rd_addr == (frame_size - FRAME_W'(1));
		end
		if (rd_s1) begin
			result_q <= store_rdata;
			last_q   <= last_s1;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_pixel = result_q;
	assign result.last_pixel   = last_q;

	// Frame store port sharing between the item path and the pass.
	always_comb begin
		ram_we    = load_wr || pass_mem.wr_en;
		ram_waddr = pass_busy ? pass_mem.wr_addr : load_q[ADDR_W-1:0];
		ram_wdata = pass_mem.wr_en ? 1'b0 : item.pixel_on;
		ram_re    = read_acc || pass_mem.rd_en;
		ram_raddr = pass_busy ? pass_mem.rd_addr : rd_addr[ADDR_W-1:0];
	end

	dwmc_ram #(
		.DATA_W (1),
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (store_rdata)
	);

	dwmc_pass u_pass (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (load_acc && item.frame_end),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.side    (side),
		.thr     (thr),
		.rd_data (store_rdata),
		.busy    (pass_busy),
		.mem     (pass_mem)
	);

endmodule

// ===== src/dwmc_checker.sv =====
// ---------------------------------------------------------------------------
// dwmc_checker
// Port-level checks of the dense window mask cleaner, bound to the top.
// ---------------------------------------------------------------------------
module dwmc_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_action,
	input logic item_frame_end,
	input logic result_valid,
	input logic result_ready
);

	// A stalled result beat stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	// A fresh result beat follows a read beat through the read stage and the output register.
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && item_action, 2))
		else $error("result beat without a read beat");

	// The window pass stalls the item channel right after frame end.
	a_pass_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_action && item_frame_end |=> !item_ready)
		else $error("item channel open after frame end");

	// No new item while a result is held back.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item taken while result stalled");

endmodule

bind dense_window_mask_clear dwmc_checker u_dwmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_action    (item.action),
	.item_frame_end (item.frame_end),
	.result_valid   (result.valid),
	.result_ready   (result.ready)
);
